// ===== design/tcw_pkg.sv =====
package tcw_pkg;

  // Default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // One cell of the store: attribute in the high byte, character in the low byte
  typedef logic [15:0] cell_t;

  localparam logic [7:0] ATTR_NORMAL  = 8'h07;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam cell_t      BLANK_CELL   = {ATTR_NORMAL, CH_SPACE};

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_LEFT  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

endpackage

// ===== design/text_console_cell_writer.sv =====
// Flow: start captures the item and moves to the execute state; the result strobe is
// registered from there for put, backspace, newline, cursor left and read, and a deferred
// wrap without scroll goes through the finish state first. Busy holds until the item is
// done, so no new item is taken before then; in a scroll or clear one cell moves or blanks
// per cycle. Reset (rst_n low, synchronous): cursor homes, then busy stays high for a
// clearing pass that fills every cell with a blank. The receiver cannot stall.
module text_console_cell_writer #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_index,
  output logic        out_valid,
  output logic [10:0] out_cursor_pos,
  output logic [4:0]  out_cursor_row_out,
  output logic [6:0]  out_cursor_col_out,
  output logic [7:0]  out_read_char,
  output logic [7:0]  out_read_attr
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);      // memory address
  localparam int PW    = $clog2(CELLS + 1);  // sweep pointers, may hold CELLS
  localparam int RW    = $clog2(ROWS);       // row never reaches ROWS
  localparam int CW    = $clog2(COLUMNS + 1);// column rests at COLUMNS on pending wrap

  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_END   = CW'(COLUMNS);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [PW-1:0] PTR_CELLS = PW'(CELLS);
  localparam logic [PW-1:0] PTR_LAST  = PW'(CELLS - 1);
  localparam logic [PW-1:0] PTR_COLS  = PW'(COLUMNS);

  typedef enum logic [1:0] {
    S_IDLE,    // wait for start
    S_EXEC,    // decode the item, do single-cell work
    S_SWEEP,   // scroll, clear or boot-time blanking, one cell per cycle
    S_FINISH   // write any pending character after a wrap or scroll, and emit the result
  } state_t;

  // Row-major linear cell number
  function automatic logic [31:0] lin_of(logic [RW-1:0] r, logic [CW-1:0] c);
    return 32'(r) * 32'(COLUMNS) + 32'(c);
  endfunction

  state_t          state_r, state_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic            pend_r, pend_nxt;   // a moved cell is in flight out of the memory
  logic            boot_r, boot_nxt;   // current sweep is the post-reset clearing pass
  tcw_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [7:0]      char_r, char_nxt;
  logic [10:0]     index_r, index_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [10:0]     out_pos_r, out_pos_nxt;
  logic [4:0]      out_row_r, out_row_nxt;
  logic [6:0]      out_col_r, out_col_nxt;
  logic [7:0]      out_char_r, out_char_nxt;
  logic [7:0]      out_attr_r, out_attr_nxt;

  // Cell memory port
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  tcw_pkg::cell_t  mem_wd;
  logic [AW-1:0]   mem_ra;
  tcw_pkg::cell_t  mem_rd;

  // Cursor one step back, used by backspace and cursor left
  logic [RW-1:0]   back_row;
  logic [CW-1:0]   back_col;
  logic [31:0]     lin_cur, lin_back, lin_out;
  logic            rd_done;
  logic            emit;

  tcw_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  always_comb begin
    if (col_r != '0) begin
      back_row = row_r;
      back_col = CW'(col_r - CW'(1));
    end else if (row_r != '0) begin
      back_row = RW'(row_r - RW'(1));
      back_col = COL_LAST;
    end else begin
      back_row = row_r;
      back_col = col_r;
    end
  end

  assign lin_cur  = lin_of(row_r, col_r);
  assign lin_back = lin_of(back_row, back_col);
  assign rd_done  = (rd_ptr_r == PTR_CELLS);

  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    pend_nxt     = 1'b0;
    boot_nxt     = boot_r;
    cmd_nxt      = cmd_r;
    char_nxt     = char_r;
    index_nxt    = index_r;
    emit         = 1'b0;
    out_char_nxt = '0;
    out_attr_nxt = '0;
    mem_we       = 1'b0;
    mem_wa       = lin_cur[AW-1:0];
    mem_wd       = tcw_pkg::BLANK_CELL;
    mem_ra       = rd_ptr_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        // Issue the read early so the cell is ready in the execute cycle
        mem_ra = AW'(in_cell_index);
        if (start) begin
          cmd_nxt   = tcw_pkg::cmd_t'(in_command);
          char_nxt  = in_char_code;
          index_nxt = in_cell_index;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (cmd_r)
          tcw_pkg::CMD_PUT: begin
            if (char_r == tcw_pkg::CH_NEWLINE) begin
              col_nxt = '0;
              if (row_r == ROW_LAST) begin
                rd_ptr_nxt = PTR_COLS;
                wr_ptr_nxt = '0;
                state_nxt  = S_SWEEP;
              end else begin
                row_nxt   = RW'(row_r + RW'(1));
                emit      = 1'b1;
                state_nxt = S_IDLE;
              end
            end else if (char_r == tcw_pkg::CH_BACKSPACE) begin
              row_nxt   = back_row;
              col_nxt   = back_col;
              mem_we    = 1'b1;
              mem_wa    = lin_back[AW-1:0];
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end else if (col_r == COL_END) begin
              // Deferred wrap: move to the next row first, scroll at the bottom
              col_nxt = '0;
              if (row_r == ROW_LAST) begin
                rd_ptr_nxt = PTR_COLS;
                wr_ptr_nxt = '0;
                state_nxt  = S_SWEEP;
              end else begin
                row_nxt   = RW'(row_r + RW'(1));
                state_nxt = S_FINISH;
              end
            end else begin
              mem_we    = 1'b1;
              mem_wd    = {tcw_pkg::ATTR_NORMAL, char_r};
              col_nxt   = CW'(col_r + CW'(1));
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          tcw_pkg::CMD_CLEAR: begin
            // Blank-only sweep: reads are marked done from the start
            row_nxt    = '0;
            col_nxt    = '0;
            rd_ptr_nxt = PTR_CELLS;
            wr_ptr_nxt = '0;
            state_nxt  = S_SWEEP;
          end
          tcw_pkg::CMD_LEFT: begin
            row_nxt   = back_row;
            col_nxt   = back_col;
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
          tcw_pkg::CMD_READ: begin
            if (32'(index_r) < 32'(CELLS)) begin
              out_char_nxt = mem_rd[7:0];
              out_attr_nxt = mem_rd[15:8];
            end
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
          default: state_nxt = S_IDLE;
        endcase
      end

      S_SWEEP: begin
        // Read stage: fetch the cell one row below the write pointer
        if (!rd_done) begin
          rd_ptr_nxt = PW'(rd_ptr_r + PW'(1));
          pend_nxt   = 1'b1;
        end
        // Write stage: move the fetched cell up, or blank once reads are done
        if (pend_r || rd_done) begin
          mem_we = 1'b1;
          mem_wa = wr_ptr_r[AW-1:0];
          mem_wd = pend_r ? mem_rd : tcw_pkg::BLANK_CELL;
          if (wr_ptr_r == PTR_LAST) begin
            state_nxt = boot_r ? S_IDLE : S_FINISH;
            boot_nxt  = 1'b0;
          end else begin
            wr_ptr_nxt = PW'(wr_ptr_r + PW'(1));
          end
        end
      end

      S_FINISH: begin
        // Printable character held back by a wrap or scroll lands now
        if (cmd_r == tcw_pkg::CMD_PUT && char_r != tcw_pkg::CH_NEWLINE) begin
          mem_we  = 1'b1;
          mem_wd  = {tcw_pkg::ATTR_NORMAL, char_r};
          col_nxt = CW'(col_r + CW'(1));
        end
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign lin_out       = lin_of(row_nxt, col_nxt);
  assign out_valid_nxt = emit;
  assign out_pos_nxt   = lin_out[10:0];
  assign out_row_nxt   = 5'(row_nxt);
  assign out_col_nxt   = 7'(col_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // Home the cursor and start the blanking pass over the whole store
      state_r     <= S_SWEEP;
      row_r       <= '0;
      col_r       <= '0;
      rd_ptr_r    <= PTR_CELLS;
      wr_ptr_r    <= '0;
      pend_r      <= 1'b0;
      boot_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      pend_r      <= pend_nxt;
      boot_r      <= boot_nxt;
      out_valid_r <= out_valid_nxt;
    end
    // Payload: no reset needed
    cmd_r      <= cmd_nxt;
    char_r     <= char_nxt;
    index_r    <= index_nxt;
    out_pos_r  <= out_pos_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_char_r <= out_char_nxt;
    out_attr_r <= out_attr_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_cursor_pos     = out_pos_r;
  assign out_cursor_row_out = out_row_r;
  assign out_cursor_col_out = out_col_r;
  assign out_read_char      = out_char_r;
  assign out_read_attr      = out_attr_r;

endmodule

// ===== design/tcw_cell_ram.sv =====
module tcw_cell_ram #(
  parameter int DEPTH = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  tcw_pkg::cell_t wr_data,
  input  logic [AW-1:0]  rd_addr,
  output tcw_pkg::cell_t rd_data
);

  tcw_pkg::cell_t mem [DEPTH];
  tcw_pkg::cell_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
